### hw/rtl/wgft_pkg.sv
// Shared types, register codes and the one-axis transform for the int8 Winograd filter transform.
// No dependencies; every other file in hw/rtl imports this package.
package wgft_pkg;

    localparam int TILE_SIZE = 4;
    localparam int KERNEL_DIM = 3;

    // configuration register indexes
    typedef logic [1:0] wgft_reg_idx_t;
    localparam wgft_reg_idx_t REG_KERNEL_ROWS = 2'd0;
    localparam wgft_reg_idx_t REG_KERNEL_COLS = 2'd1;

    // tap counts of one axis
    localparam logic [1:0] TAPS_NONE  = 2'd0;
    localparam logic [1:0] TAPS_PASS  = 2'd1;
    localparam logic [1:0] TAPS_TWO   = 2'd2;
    localparam logic [1:0] TAPS_THREE = 2'd3;

    // one kernel as it arrives
    typedef struct packed {
        logic signed [7:0] w_r0c0;
        logic signed [7:0] w_r0c1;
        logic signed [7:0] w_r0c2;
        logic signed [7:0] w_r1c0;
        logic signed [7:0] w_r1c1;
        logic signed [7:0] w_r1c2;
        logic signed [7:0] w_r2c0;
        logic signed [7:0] w_r2c1;
        logic signed [7:0] w_r2c2;
    } wgft_in_t;

    // one transformed tile
    typedef struct packed {
        logic [31:0] tile_row0;
        logic [31:0] tile_row1;
        logic [31:0] tile_row2;
        logic [31:0] tile_row3;
        logic        overflow;
    } wgft_out_t;

    // entry stage: kernel plus the sizes it was accepted under
    typedef struct packed {
        wgft_in_t   kernel;
        logic [1:0] rows;
        logic [1:0] cols;
    } wgft_entry_t;

    // after the column pass: mid[row][col]
    typedef struct packed {
        logic [TILE_SIZE-1:0][KERNEL_DIM-1:0][7:0] mid;
        logic [1:0] cols;
        logic       bad;
        logic       ovf;
    } wgft_mid_t;

    // result of one axis transform
    typedef struct packed {
        logic [TILE_SIZE-1:0][7:0] lane;
        logic                      ovf;
    } wgft_axis_t;

    // Transform up to three taps into four int8 lanes; flag sums that leave int8.
    function automatic wgft_axis_t wgft_axis(
        input logic [7:0] x0,
        input logic [7:0] x1,
        input logic [7:0] x2,
        input logic [1:0] taps
    );
        wgft_axis_t        res;
        logic signed [9:0] e0;
        logic signed [9:0] e1;
        logic signed [9:0] e2;
        logic signed [9:0] sp;
        logic signed [9:0] sm;
        e0 = {{2{x0[7]}}, x0};
        e1 = {{2{x1[7]}}, x1};
        e2 = (taps == TAPS_THREE) ? {{2{x2[7]}}, x2} : 10'sd0;
        sp = e0 + e1 + e2;
        sm = e0 - e1 + e2;
        res = '0;
        case (taps)
            TAPS_THREE, TAPS_TWO:
            begin
                res.lane[0] = x0;
                res.lane[1] = sp[7:0];
                res.lane[2] = sm[7:0];
                res.lane[3] = (taps == TAPS_THREE) ? x2 : x1;
                res.ovf     = (sp[9:7] != 3'b000 && sp[9:7] != 3'b111) ||
                              (sm[9:7] != 3'b000 && sm[9:7] != 3'b111);
            end
            default:
            begin
                // single tap or no size: pass lane 0 through
                res.lane[0] = x0;
            end
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/winograd_int8_filter_transform.sv
// Winograd F(2x2,3x3) int8 filter transform: a kernel passes the entry, column-pass
// and row-pass registers in that order; the entry stage only registers.
// Throughput: one kernel per cycle while tile_ready is high; each pass is one stage.
// Reset: pipeline empty, kernel_rows and kernel_cols set to 3; cfg writes always accepted.
// Depends on wgft_pkg, wgft_col_stage, wgft_row_stage.
module winograd_int8_filter_transform
    import wgft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          kernel_valid,
    output logic          kernel_ready,
    input  wgft_in_t      kernel,
    output logic          tile_valid,
    input  logic          tile_ready,
    output wgft_out_t     tile,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  wgft_reg_idx_t cfg_index,
    input  logic [1:0]    cfg_data
);

    logic [1:0]  kernel_rows_reg;
    logic [1:0]  kernel_cols_reg;
    wgft_entry_t entry_reg;
    logic        entry_valid_reg;
    logic        col_ready;
    logic        mid_valid;
    logic        mid_ready;
    wgft_mid_t   mid_data;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_rows_reg <= TAPS_THREE;
            kernel_cols_reg <= TAPS_THREE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_KERNEL_ROWS)
            begin
                kernel_rows_reg <= cfg_data;
            end
            if (cfg_index == REG_KERNEL_COLS)
            begin
                kernel_cols_reg <= cfg_data;
            end
        end
    end

    // Entry register: capture the kernel with its sizes
    assign kernel_ready = !entry_valid_reg || col_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (kernel_ready)
        begin
            entry_valid_reg <= kernel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kernel_valid && kernel_ready)
        begin
            entry_reg.kernel <= kernel;
            entry_reg.rows   <= kernel_rows_reg;
            entry_reg.cols   <= kernel_cols_reg;
        end
    end

    wgft_col_stage u_col_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (entry_valid_reg),
        .in_ready  (col_ready),
        .in_data   (entry_reg),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    wgft_row_stage u_row_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (tile_valid),
        .out_ready (tile_ready),
        .out_data  (tile)
    );

    // A stalled entry item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid_reg && !col_ready |=> entry_valid_reg && $stable(entry_reg))
        else $error("entry stage lost a stalled item");

    // A rows write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == REG_KERNEL_ROWS |=> kernel_rows_reg == $past(cfg_data))
        else $error("kernel_rows write lost");

    // A cols write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == REG_KERNEL_COLS |=> kernel_cols_reg == $past(cfg_data))
        else $error("kernel_cols write lost");

endmodule

### hw/rtl/wgft_col_stage.sv
// Column pass pipeline stage: transforms each kernel column along the row axis.
// Depends on wgft_pkg.
module wgft_col_stage
    import wgft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  wgft_entry_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output wgft_mid_t   out_data
);

    logic [KERNEL_DIM-1:0][KERNEL_DIM-1:0][7:0] w;
    logic [KERNEL_DIM-1:0]                      col_used;
    wgft_axis_t [KERNEL_DIM-1:0]                col_res;
    wgft_mid_t                                  mid_next;
    wgft_mid_t                                  mid_reg;
    logic                                       valid_reg;

    // Unpack the kernel into a row/column grid
    always_comb
    begin
        w[0][0] = in_data.kernel.w_r0c0;
        w[0][1] = in_data.kernel.w_r0c1;
        w[0][2] = in_data.kernel.w_r0c2;
        w[1][0] = in_data.kernel.w_r1c0;
        w[1][1] = in_data.kernel.w_r1c1;
        w[1][2] = in_data.kernel.w_r1c2;
        w[2][0] = in_data.kernel.w_r2c0;
        w[2][1] = in_data.kernel.w_r2c1;
        w[2][2] = in_data.kernel.w_r2c2;
    end

    // Only columns inside the kernel width count toward overflow
    assign col_used[0] = 1'b1;
    assign col_used[1] = (in_data.cols == TAPS_TWO) || (in_data.cols == TAPS_THREE);
    assign col_used[2] = (in_data.cols == TAPS_THREE);

    // Transform every column
    always_comb
    begin
        mid_next      = '0;
        mid_next.cols = in_data.cols;
        mid_next.bad  = (in_data.rows == TAPS_NONE) || (in_data.cols == TAPS_NONE);
        for (int c = 0; c < KERNEL_DIM; c++)
        begin
            col_res[c] = wgft_axis(w[0][c], w[1][c], w[2][c], in_data.rows);
            for (int i = 0; i < TILE_SIZE; i++)
            begin
                mid_next.mid[i][c] = col_res[c].lane[i];
            end
            mid_next.ovf = mid_next.ovf | (col_res[c].ovf & col_used[c]);
        end
    end

    // Advance when the next stage is free or taking its item
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mid_reg <= mid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = mid_reg;

endmodule

### hw/rtl/wgft_row_stage.sv
// Row pass pipeline stage and output register: transforms each intermediate row.
// Depends on wgft_pkg.
module wgft_row_stage
    import wgft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  wgft_mid_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output wgft_out_t out_data
);

    wgft_axis_t [TILE_SIZE-1:0] row_res;
    wgft_out_t                  tile_next;
    wgft_out_t                  tile_reg;
    logic                       valid_reg;
    logic                       row_ovf;

    // Transform every intermediate row along the column axis
    always_comb
    begin
        row_ovf = in_data.ovf;
        for (int r = 0; r < TILE_SIZE; r++)
        begin
            row_res[r] = wgft_axis(in_data.mid[r][0], in_data.mid[r][1],
                                   in_data.mid[r][2], in_data.cols);
            row_ovf    = row_ovf | row_res[r].ovf;
        end
    end

    // Zero the tile and flag it when the size is unsupported, else take the row results
    always_comb
    begin
        if (in_data.bad)
        begin
            tile_next          = '0;
            tile_next.overflow = 1'b1;
        end
        else
        begin
            tile_next.tile_row0 = row_res[0].lane;
            tile_next.tile_row1 = row_res[1].lane;
            tile_next.tile_row2 = row_res[2].lane;
            tile_next.tile_row3 = row_res[3].lane;
            tile_next.overflow  = row_ovf;
        end
    end

    // Hold the result until the consumer takes it
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tile_reg <= tile_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = tile_reg;

    // A transfer into this stage always shows up at the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg)
        else $error("row stage dropped a transfer");

    // An unsupported size always yields a flagged tile with rows 0 and 3 zero
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.bad |=>
            tile_reg.overflow && tile_reg.tile_row0 == '0 && tile_reg.tile_row3 == '0)
        else $error("unsupported size not flagged");

    // A result the consumer holds off stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(tile_reg))
        else $error("stalled tile changed");

endmodule
